// ----- hw/rtl/spectral_peak_detector_assert.svh -----
// assertion macros for the spectral peak detector
// used by spd_back to check its own control logic; no other dependencies
`ifndef SPECTRAL_PEAK_DETECTOR_ASSERT_SVH
`define SPECTRAL_PEAK_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);
`define SPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);
`else
`define SPD_ASSERT(lbl, ck, rn, expr, msg)
`define SPD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/spd_pkg.sv -----
// shared constants, types and state encodings of the spectral peak detector
// no dependencies
`default_nettype none
package spd_pkg;
    localparam int MAX_BINS   = 4096;
    localparam int BIN_W      = 13;
    localparam int MAX_PEAKS  = 16;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int POWER_W    = 32;
    localparam int FRAC_BITS  = 8;
    localparam int POS_W      = 20;
    localparam int SNR_W      = 24;
    localparam int LOG_W      = 18;
    localparam int LOG_FRAC   = 10;
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [LOG_W-1:0] LOG_FLOOR = LOG_W'(-(64 << LOG_FRAC));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEDIAN    = 3'd0,
        CFG_SCALE     = 3'd1,
        CFG_GUARD     = 3'd2,
        CFG_EXCL_LO   = 3'd3,
        CFG_EXCL_HI   = 3'd4,
        CFG_MAX_PEAKS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0] median_level;
        logic [15:0] threshold_scale;
        logic [11:0] guard_bins;
        logic [12:0] exclude_low;
        logic [12:0] exclude_high;
        logic [4:0]  max_peaks;
    } cfg_t;

    // one unit of work handed from the front to the back
    typedef struct packed {
        logic               cand;
        logic               fend;
        logic               ovf;
        logic [BIN_W-1:0]   bin;
        logic [POWER_W-1:0] mid;
        logic [LOG_W-1:0]   y1;
        logic [LOG_W-1:0]   y2;
        logic [LOG_W-1:0]   y3;
    } job_t;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} log_state_t;
    typedef enum logic [2:0] {F_IDLE, F_LOG, F_JUDGE, F_PUSH} front_state_t;
    typedef enum logic [3:0] {
        B_IDLE, B_TRUNC, B_CHECK, B_EVICT, B_VSTART, B_VWAIT,
        B_RSTART, B_RWAIT, B_INSERT, B_FEND, B_EMIT
    } back_state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/spd_log2.sv -----
// iterative log2 in Q.10: binary normalize, then one squaring per fraction bit
// depends on spd_pkg
`default_nettype none
module spd_log2
    import spd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [POWER_W-1:0] value,
    output logic                    done,
    output logic [LOG_W-1:0]        result
);
    log_state_t       state_reg, state_next;
    logic [31:0]      m_reg, m_next;
    logic [4:0]       exp_reg, exp_next;
    logic [9:0]       frac_reg, frac_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             zero_reg, zero_next;
    logic             done_reg, done_next;
    logic [LOG_W-1:0] res_reg, res_next;
    logic [63:0]      sq;
    logic [32:0]      sq_sh;
    logic             top_zero;
    logic [4:0]       k;

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        exp_reg  <= exp_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        exp_next   = exp_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        zero_next  = zero_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        sq         = m_reg * m_reg;
        sq_sh      = sq[63:31];
        k          = 5'd16 >> cnt_reg;
        case (cnt_reg)
            4'd0:    top_zero = (m_reg[31:16] == 16'd0);
            4'd1:    top_zero = (m_reg[31:24] == 8'd0);
            4'd2:    top_zero = (m_reg[31:28] == 4'd0);
            4'd3:    top_zero = (m_reg[31:30] == 2'd0);
            default: top_zero = !m_reg[31];
        endcase
        case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    m_next     = value;
                    exp_next   = 5'd31;
                    frac_next  = 10'd0;
                    cnt_next   = 4'd0;
                    zero_next  = (value == '0);
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                if (top_zero)
                begin
                    m_next   = m_reg << k;
                    exp_next = exp_reg - k;
                end
                if (cnt_reg == 4'd4)
                begin
                    cnt_next   = 4'd0;
                    state_next = L_SQ;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            L_SQ:
            begin
                frac_next = {frac_reg[8:0], sq_sh[32]};
                m_next    = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'(LOG_FRAC - 1))
                begin
                    res_next   = zero_reg ? LOG_FLOOR : {3'd0, exp_reg, frac_next};
                    done_next  = 1'b1;
                    state_next = L_IDLE;
                end
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/spd_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on spd_pkg
`default_nettype none
module spd_div
    import spd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic                      done,
    output logic [DIV_NUM_W-1:0]      quo
);
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W+1:0] trial;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        trial     = {1'b0, shifted} - {2'b0, den_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = 6'(DIV_NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[DIV_DEN_W+1])
            begin
                rem_next = trial[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/spd_front.sv -----
// front end: takes bins, computes log2, classifies local maxima and frame ends
// depends on spd_pkg and spd_log2
`default_nettype none
module spd_front
    import spd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               start,
    input  wire logic [POWER_W-1:0] power,
    input  wire logic               frame_end,
    output logic                    busy,
    output logic                    push,
    output job_t                    job,
    input  wire logic               full
);
    front_state_t       state_reg, state_next;
    logic [BIN_W-1:0]   cnt_reg, cnt_next;
    logic [POWER_W-1:0] pp0_reg, pp0_next, pp1_reg, pp1_next;
    logic [LOG_W-1:0]   pl0_reg, pl0_next, pl1_reg, pl1_next;
    logic               ovf_reg, ovf_next;
    logic [POWER_W-1:0] p_reg, p_next;
    logic               end_reg, end_next;
    logic [LOG_W-1:0]   lg_reg, lg_next;
    job_t               job_reg, job_next;
    logic               log_start, log_done;
    logic [LOG_W-1:0]   log_res;
    logic [BIN_W-1:0]   idx;
    logic [47:0]        thr;
    logic               excluded, cand;
    logic               started_reg, started_next;

    spd_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .value  (p_reg),
        .done   (log_done),
        .result (log_res)
    );

    assign busy = (state_reg != F_IDLE);
    assign job  = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
            pp0_reg   <= '0;
            pp1_reg   <= '0;
            pl0_reg   <= '0;
            pl1_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pp0_reg   <= pp0_next;
            pp1_reg   <= pp1_next;
            pl0_reg   <= pl0_next;
            pl1_reg   <= pl1_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        end_reg <= end_next;
        lg_reg  <= lg_next;
        job_reg <= job_next;
    end

    always_comb
    begin
        idx      = cnt_reg - BIN_W'(1);
        thr      = cfg.median_level * cfg.threshold_scale;
        excluded = (cfg.exclude_low < cfg.exclude_high) && (idx >= cfg.exclude_low)
                   && (idx < cfg.exclude_high);
        cand     = (cnt_reg >= BIN_W'(2)) && !excluded && (pp1_reg >= pp0_reg)
                   && (pp1_reg > p_reg) && ({8'd0, pp1_reg, 8'd0} > thr);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pp0_next   = pp0_reg;
        pp1_next   = pp1_reg;
        pl0_next   = pl0_reg;
        pl1_next   = pl1_reg;
        ovf_next   = ovf_reg;
        p_next     = p_reg;
        end_next   = end_reg;
        lg_next    = lg_reg;
        job_next   = job_reg;
        log_start  = 1'b0;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    p_next   = power;
                    end_next = frame_end;
                    if (cnt_reg >= BIN_W'(MAX_BINS))
                    begin
                        ovf_next = 1'b1;
                        if (frame_end)
                        begin
                            job_next      = '0;
                            job_next.fend = 1'b1;
                            job_next.ovf  = 1'b1;
                            cnt_next      = '0;
                            pp0_next      = '0;
                            pp1_next      = '0;
                            pl0_next      = '0;
                            pl1_next      = '0;
                            ovf_next      = 1'b0;
                            state_next    = F_PUSH;
                        end
                    end
                    else
                    begin
                        state_next = F_LOG;
                    end
                end
            end
            F_LOG:
            begin
                // kick the log unit on the first cycle, then wait for it
                log_start = !started_reg;
                if (log_done)
                begin
                    lg_next    = log_res;
                    state_next = F_JUDGE;
                end
            end
            F_JUDGE:
            begin
                job_next.cand = cand;
                job_next.fend = end_reg;
                job_next.ovf  = ovf_reg;
                job_next.bin  = idx;
                job_next.mid  = pp1_reg;
                job_next.y1   = pl0_reg;
                job_next.y2   = pl1_reg;
                job_next.y3   = lg_reg;
                if (end_reg)
                begin
                    cnt_next = '0;
                    pp0_next = '0;
                    pp1_next = '0;
                    pl0_next = '0;
                    pl1_next = '0;
                    ovf_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg + BIN_W'(1);
                    pp0_next = pp1_reg;
                    pp1_next = p_reg;
                    pl0_next = pl1_reg;
                    pl1_next = lg_reg;
                end
                state_next = (cand || end_reg) ? F_PUSH : F_IDLE;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // log unit is started exactly once, on entry to the log wait state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            started_reg <= 1'b0;
        else
            started_reg <= started_next;
    end

    always_comb
    begin
        started_next = (state_reg == F_LOG) && !log_done;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/spd_queue.sv -----
// two-entry queue between the front end and the list engine
// depends on spd_pkg
`default_nettype none
module spd_queue
    import spd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t wdata,
    input  wire logic pop,
    output job_t      head,
    output logic      full,
    output logic      empty
);
    job_t       mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/spd_back.sv -----
// list engine: suppression, eviction, interpolation, sorted insertion, emission
// depends on spd_pkg, spd_div and the assertion macro header
`default_nettype none
`include "spectral_peak_detector_assert.svh"
module spd_back
    import spd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          empty,
    input  wire job_t          head,
    output logic               pop,
    output logic               result_valid,
    output logic [POS_W-1:0]   peak_bin,
    output logic [POWER_W-1:0] peak_power,
    output logic [SNR_W-1:0]   peak_snr,
    output logic [IDX_W-1:0]   peak_rank,
    output logic [CNT_W-1:0]   peak_total,
    output logic               no_peaks,
    output logic               frame_overflow,
    output logic               last_result
);
    back_state_t        state_reg, state_next;
    job_t               cur_reg, cur_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   emit_reg, emit_next;
    logic [POS_W-1:0]   pos_reg [MAX_PEAKS];
    logic [POS_W-1:0]   pos_next [MAX_PEAKS];
    logic [POWER_W-1:0] pow_reg [MAX_PEAKS];
    logic [POWER_W-1:0] pow_next [MAX_PEAKS];
    logic [SNR_W-1:0]   rat_reg [MAX_PEAKS];
    logic [SNR_W-1:0]   rat_next [MAX_PEAKS];
    logic signed [9:0]  vtx_reg, vtx_next;
    logic               vneg_reg, vneg_next;
    logic [SNR_W-1:0]   ratio_reg, ratio_next;

    logic               rv_reg, rv_next;
    logic [POS_W-1:0]   ob_reg, ob_next;
    logic [POWER_W-1:0] op_reg, op_next;
    logic [SNR_W-1:0]   os_reg, os_next;
    logic [IDX_W-1:0]   ork_reg, ork_next;
    logic [CNT_W-1:0]   ot_reg, ot_next;
    logic               onp_reg, onp_next;
    logic               oov_reg, oov_next;
    logic               ol_reg, ol_next;

    logic [MAX_PEAKS-1:0] valid_v, near_v, strong_v;
    logic [CNT_W-1:0]     lim, ins;
    logic [IDX_W-1:0]     first;
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic signed [18:0]   ydiff;
    logic signed [20:0]   den;
    logic signed [21:0]   den2;
    logic signed [26:0]   vnum;
    logic [POS_W-1:0]     place;

    spd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign result_valid   = rv_reg;
    assign peak_bin       = ob_reg;
    assign peak_power     = op_reg;
    assign peak_snr       = os_reg;
    assign peak_rank      = ork_reg;
    assign peak_total     = ot_reg;
    assign no_peaks       = onp_reg;
    assign frame_overflow = oov_reg;
    assign last_result    = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        emit_reg  <= emit_next;
        pos_reg   <= pos_next;
        pow_reg   <= pow_next;
        rat_reg   <= rat_next;
        vtx_reg   <= vtx_next;
        vneg_reg  <= vneg_next;
        ratio_reg <= ratio_next;
        ob_reg    <= ob_next;
        op_reg    <= op_next;
        os_reg    <= os_next;
        ork_reg   <= ork_next;
        ot_reg    <= ot_next;
        onp_reg   <= onp_next;
        oov_reg   <= oov_next;
        ol_reg    <= ol_next;
    end

    // per-entry comparisons against the current candidate
    always_comb
    begin
        logic signed [21:0] diff;
        logic [21:0]        sep;
        for (int k = 0; k < MAX_PEAKS; k++)
        begin
            diff        = $signed({2'b0, pos_reg[k]}) - $signed({1'b0, cur_reg.bin, 8'd0});
            sep         = diff[21] ? 22'(-diff) : 22'(diff);
            valid_v[k]  = (CNT_W'(k) < count_reg);
            near_v[k]   = (sep <= {2'b0, cfg.guard_bins, 8'd0});
            strong_v[k] = (pow_reg[k] >= cur_reg.mid);
        end
        first = '0;
        for (int k = MAX_PEAKS - 1; k >= 0; k--)
        begin
            if (valid_v[k] && near_v[k])
                first = IDX_W'(k);
        end
        ins = CNT_W'($countones(valid_v & strong_v));
        lim = (cfg.max_peaks > CNT_W'(MAX_PEAKS)) ? CNT_W'(MAX_PEAKS) : cfg.max_peaks;
    end

    always_comb
    begin
        ydiff = 19'($signed(cur_reg.y1)) - 19'($signed(cur_reg.y3));
        den   = 21'($signed(cur_reg.y1)) - (21'($signed(cur_reg.y2)) <<< 1)
                + 21'($signed(cur_reg.y3));
        den2  = 22'(den) <<< 1;
        vnum  = 27'(ydiff) <<< FRAC_BITS;
        place = POS_W'({cur_reg.bin, 8'd0}) + POS_W'(vtx_reg);
    end

    always_comb
    begin
        logic [IDX_W-1:0] src;
        state_next = state_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        emit_next  = emit_reg;
        pos_next   = pos_reg;
        pow_next   = pow_reg;
        rat_next   = rat_reg;
        vtx_next   = vtx_reg;
        vneg_next  = vneg_reg;
        ratio_next = ratio_reg;
        rv_next    = 1'b0;
        ob_next    = ob_reg;
        op_next    = op_reg;
        os_next    = os_reg;
        ork_next   = ork_reg;
        ot_next    = ot_reg;
        onp_next   = onp_reg;
        oov_next   = oov_reg;
        ol_next    = ol_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        src        = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    state_next = head.cand ? B_TRUNC : B_FEND;
                end
            end
            B_TRUNC:
            begin
                if (count_reg > lim)
                    count_next = lim;
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                // a stronger or equal peak nearby drops the candidate
                state_next = ((valid_v & near_v & strong_v) != '0) ? B_FEND : B_EVICT;
            end
            B_EVICT:
            begin
                if ((valid_v & near_v) != '0)
                begin
                    for (int k = 0; k < MAX_PEAKS - 1; k++)
                    begin
                        if (IDX_W'(k) >= first)
                        begin
                            pos_next[k] = pos_reg[k + 1];
                            pow_next[k] = pow_reg[k + 1];
                            rat_next[k] = rat_reg[k + 1];
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = B_VSTART;
                end
            end
            B_VSTART:
            begin
                if (den == '0)
                begin
                    vtx_next   = '0;
                    state_next = B_RSTART;
                end
                else
                begin
                    vneg_next  = vnum[26] ^ den2[21];
                    div_start  = 1'b1;
                    div_num    = DIV_NUM_W'(vnum[26] ? 27'(-vnum) : 27'(vnum));
                    div_den    = DIV_DEN_W'(den2[21] ? 22'(-den2) : 22'(den2));
                    state_next = B_VWAIT;
                end
            end
            B_VWAIT:
            begin
                if (div_done)
                begin
                    if (div_quo > DIV_NUM_W'(1 << (FRAC_BITS - 1)))
                        vtx_next = 10'sd128;
                    else
                        vtx_next = $signed(10'(div_quo));
                    if (vneg_reg)
                        vtx_next = -vtx_next;
                    state_next = B_RSTART;
                end
            end
            B_RSTART:
            begin
                if (cfg.median_level == '0)
                begin
                    ratio_next = '0;
                    state_next = B_INSERT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {cur_reg.mid, 8'd0};
                    div_den    = cfg.median_level;
                    state_next = B_RWAIT;
                end
            end
            B_RWAIT:
            begin
                if (div_done)
                begin
                    ratio_next = (div_quo > DIV_NUM_W'({SNR_W{1'b1}})) ? {SNR_W{1'b1}}
                                 : div_quo[SNR_W-1:0];
                    state_next = B_INSERT;
                end
            end
            B_INSERT:
            begin
                if (ins < lim)
                begin
                    for (int k = 0; k < MAX_PEAKS; k++)
                    begin
                        src = IDX_W'((k == 0) ? 0 : k - 1);
                        if (CNT_W'(k) == ins)
                        begin
                            pos_next[k] = place;
                            pow_next[k] = cur_reg.mid;
                            rat_next[k] = ratio_reg;
                        end
                        else if (CNT_W'(k) > ins && CNT_W'(k) < lim)
                        begin
                            pos_next[k] = pos_reg[src];
                            pow_next[k] = pow_reg[src];
                            rat_next[k] = rat_reg[src];
                        end
                    end
                    if (count_reg < lim)
                        count_next = count_reg + CNT_W'(1);
                end
                state_next = B_FEND;
            end
            B_FEND:
            begin
                if (cur_reg.fend)
                begin
                    if (count_reg > lim)
                        count_next = lim;
                    emit_next  = '0;
                    state_next = B_EMIT;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            B_EMIT:
            begin
                rv_next  = 1'b1;
                oov_next = cur_reg.ovf;
                if (count_reg == '0)
                begin
                    ob_next    = '0;
                    op_next    = '0;
                    os_next    = '0;
                    ork_next   = '0;
                    ot_next    = '0;
                    onp_next   = 1'b1;
                    ol_next    = 1'b1;
                    state_next = B_IDLE;
                end
                else
                begin
                    ob_next   = pos_reg[emit_reg];
                    op_next   = pow_reg[emit_reg];
                    os_next   = rat_reg[emit_reg];
                    ork_next  = emit_reg;
                    ot_next   = count_reg;
                    onp_next  = 1'b0;
                    ol_next   = (CNT_W'(emit_reg) + CNT_W'(1) == count_reg);
                    emit_next = emit_reg + IDX_W'(1);
                    if (CNT_W'(emit_reg) + CNT_W'(1) == count_reg)
                    begin
                        count_next = '0;
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    `SPD_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_PEAKS), "list count too big")
    `SPD_ASSERT(a_no_peaks_last, clk, rst_n, !(rv_reg && onp_reg) || ol_reg, "no_peaks not last")
    `SPD_ASSERT_NEXT(a_frame_clears, clk, rst_n, rv_reg && ol_reg, count_reg == '0, "list kept")
    `SPD_ASSERT(a_pop_nonempty, clk, rst_n, !pop || !empty, "pop from empty queue")
endmodule
`default_nettype wire

// ----- hw/rtl/spectral_peak_detector.sv -----
// top level of the spectral peak detector: configuration registers and wiring
// depends on spd_pkg, spd_front, spd_queue, spd_back
//
// Usage: drive one spectrum bin per command: start high with power and
// frame_end is taken at a clock edge where busy is low. After a transfer busy
// stays high through the log2 unit (start, 5 normalize steps and 10 squarings,
// its result register), the classify step and, when a job goes to the queue,
// the push, so a new bin is not taken until the last one is done; longer while
// the queue is full. The list engine takes each candidate in turn, evicting
// near entries one at a time (up to 16), then up to two divider passes (start,
// 40 quotient bits, done) for vertex offset and snr, skipped when the curvature
// or median_level is zero, so dense candidates back-pressure via busy.
// At the bin flagged frame_end the list is emitted strongest first, one result
// per cycle on result_valid, last_result on the final one. A frame with no
// peaks gives one result with no_peaks set. Results cannot be held off.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears frame state and restores register defaults; no clearing pass.
`default_nettype none
module spectral_peak_detector
    import spd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [POWER_W-1:0]    power,
    input  wire logic                  frame_end,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       result_valid,
    output logic [POS_W-1:0]           peak_bin,
    output logic [POWER_W-1:0]         peak_power,
    output logic [SNR_W-1:0]           peak_snr,
    output logic [IDX_W-1:0]           peak_rank,
    output logic [CNT_W-1:0]           peak_total,
    output logic                       no_peaks,
    output logic                       frame_overflow,
    output logic                       last_result
);
    cfg_t cfg_reg;
    logic push, pop, full, empty;
    job_t job, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.median_level    <= '0;
            cfg_reg.threshold_scale <= 16'd1024;
            cfg_reg.guard_bins      <= 12'd2;
            cfg_reg.exclude_low     <= '0;
            cfg_reg.exclude_high    <= '0;
            cfg_reg.max_peaks       <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MEDIAN:    cfg_reg.median_level    <= cfg_data;
                CFG_SCALE:     cfg_reg.threshold_scale <= cfg_data[15:0];
                CFG_GUARD:     cfg_reg.guard_bins      <= cfg_data[11:0];
                CFG_EXCL_LO:   cfg_reg.exclude_low     <= cfg_data[12:0];
                CFG_EXCL_HI:   cfg_reg.exclude_high    <= cfg_data[12:0];
                CFG_MAX_PEAKS: cfg_reg.max_peaks       <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    spd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (start),
        .power     (power),
        .frame_end (frame_end),
        .busy      (busy),
        .push      (push),
        .job       (job),
        .full      (full)
    );

    spd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job),
        .pop   (pop),
        .head  (head),
        .full  (full),
        .empty (empty)
    );

    spd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .peak_bin       (peak_bin),
        .peak_power     (peak_power),
        .peak_snr       (peak_snr),
        .peak_rank      (peak_rank),
        .peak_total     (peak_total),
        .no_peaks       (no_peaks),
        .frame_overflow (frame_overflow),
        .last_result    (last_result)
    );
endmodule
`default_nettype wire
